// ----- sv/scsimb_pkg.sv -----
// Package: word types, register offsets, command codes and helpers for the mailbox registers
package scsimb_pkg;

	localparam int REG_WINDOW = 96;
	localparam int OFF_W      = $clog2(REG_WINDOW);

	localparam logic [11:0] WIN_BASE = 12'hc80;

	localparam logic [OFF_W-1:0] OFF_INTDEF = OFF_W'(8'h42);
	localparam logic [OFF_W-1:0] OFF_MBO    = OFF_W'(8'h50);
	localparam logic [OFF_W-1:0] OFF_ATTN   = OFF_W'(8'h54);
	localparam logic [OFF_W-1:0] OFF_CTRL   = OFF_W'(8'h55);
	localparam logic [OFF_W-1:0] OFF_INTST  = OFF_W'(8'h56);
	localparam logic [OFF_W-1:0] OFF_STAT   = OFF_W'(8'h57);
	localparam logic [OFF_W-1:0] OFF_MBI    = OFF_W'(8'h58);
	localparam logic [OFF_W-1:0] OFF_READY  = OFF_W'(8'h5c);

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_DONE  = 2'd2;

	localparam logic [2:0] ST_MBFREE = 3'b100;
	localparam logic [2:0] ST_INTPND = 3'b010;
	localparam logic [2:0] ST_BUSY   = 3'b001;

	localparam logic [3:0] ATT_IMMED = 4'h1;
	localparam logic [3:0] ATT_START = 4'h4;
	localparam logic [3:0] ATT_ABORT = 4'h5;

	localparam int CT_RESET = 7;
	localparam int CT_ICLR  = 6;
	localparam int CT_READY = 5;

	localparam logic [7:0] CODE_GOOD  = 8'h10;
	localparam logic [7:0] CODE_IMMED = 8'ha0;
	localparam logic [7:0] CODE_ERROR = 8'hc0;

	localparam logic CFG_SLOT_ID = 1'b0;

	typedef struct packed {
		logic [1:0]  operation;
		logic [11:0] port_address;
		logic [7:0]  write_data;
		logic        completion_ok;
	} in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        irq_asserted;
		logic [3:0]  irq_number;
		logic        start_request;
		logic [31:0] start_address;
		logic [3:0]  start_target;
	} out_t;

	typedef struct packed {
		logic             en;
		logic [OFF_W-1:0] addr;
		logic [7:0]       data;
	} wr_t;

	function automatic logic win_hit(input logic [11:0] port);
		logic [12:0] diff;
		diff = {1'b0, port} - {1'b0, WIN_BASE};
		return !diff[12] && (diff < 13'(REG_WINDOW));
	endfunction

	function automatic logic [OFF_W-1:0] win_off(input logic [11:0] port);
		logic [11:0] diff;
		diff = port - WIN_BASE;
		return diff[OFF_W-1:0];
	endfunction

	function automatic logic [3:0] irq_lookup(input logic [2:0] sel);
		logic [3:0] irq;
		unique case (sel)
			3'd0: irq = 4'd9;
			3'd1: irq = 4'd10;
			3'd2: irq = 4'd11;
			3'd3: irq = 4'd12;
			3'd4: irq = 4'd0;
			3'd5: irq = 4'd14;
			3'd6: irq = 4'd15;
			3'd7: irq = 4'd0;
			default: irq = 4'd0;
		endcase
		return irq;
	endfunction

endpackage

// ----- sv/scsimb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data
module scsimb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 96
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- sv/scsimb_regs.sv -----
// Mailbox, status, attention and interrupt registers with the per-word update logic
module scsimb_regs (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 commit,
	input  scsimb_pkg::in_t      item,
	input  logic [7:0]           ram_byte,
	input  logic [31:0]          slot_id,
	output scsimb_pkg::out_t     result,
	output scsimb_pkg::wr_t      wr
);
	import scsimb_pkg::*;

	logic [31:0] mbo_q, mbo_d;
	logic [31:0] mbi_q, mbi_d;
	logic [2:0]  stat_q, stat_d;
	logic [7:0]  intst_q, intst_d;
	logic        ready_q, ready_d;
	logic [7:0]  attn_q, attn_d;
	logic [31:0] paddr_q, paddr_d;
	logic [3:0]  ptgt_q, ptgt_d;
	logic        irq_q, irq_d;
	logic [3:0]  isel_q, isel_d;

	logic             hit;
	logic [OFF_W-1:0] off;
	logic [7:0]       val;

	assign hit = win_hit(item.port_address);
	assign off = win_off(item.port_address);
	assign val = item.write_data;

	always_comb begin
		mbo_d   = mbo_q;
		mbi_d   = mbi_q;
		stat_d  = stat_q;
		intst_d = intst_q;
		ready_d = ready_q;
		attn_d  = attn_q;
		paddr_d = paddr_q;
		ptgt_d  = ptgt_q;
		irq_d   = irq_q;
		isel_d  = isel_q;
		wr      = '0;
		result  = '0;

		unique case (item.operation)
			OP_READ: begin
				if (!hit) begin
					result.read_data = 8'hff;
				end else if (off[OFF_W-1:2] == '0) begin
					result.read_data = slot_id[8*off[1:0] +: 8];
				end else if (off[OFF_W-1:2] == OFF_MBO[OFF_W-1:2]) begin
					result.read_data = mbo_q[8*off[1:0] +: 8];
				end else if (off[OFF_W-1:2] == OFF_MBI[OFF_W-1:2]) begin
					result.read_data = mbi_q[8*off[1:0] +: 8];
				end else if (off == OFF_STAT) begin
					result.read_data = {5'b0, stat_q};
				end else if (off == OFF_INTST) begin
					result.read_data = intst_q;
				end else if (off == OFF_READY) begin
					result.read_data = {7'b0, ready_q};
				end else if (off == OFF_ATTN) begin
					result.read_data = attn_q;
				end else begin
					result.read_data = ram_byte;
				end
			end
			OP_WRITE: begin
				if (!hit) begin
					// outside the window: nothing
				end else if (off[OFF_W-1:2] == OFF_MBO[OFF_W-1:2]) begin
					mbo_d[8*off[1:0] +: 8] = val;
					if (off[1:0] == 2'd3) begin
						stat_d = stat_d & ~ST_MBFREE;
					end
				end else if (off == OFF_ATTN) begin
					attn_d = val;
					if (val[7:4] == ATT_START) begin
						paddr_d               = mbo_q;
						ptgt_d                = val[3:0];
						stat_d                = stat_d | ST_BUSY;
						result.start_request  = 1'b1;
						result.start_address  = mbo_q;
						result.start_target   = val[3:0];
					end else if (val[7:4] == ATT_ABORT || val[7:4] == ATT_IMMED) begin
						mbi_d   = mbo_q;
						intst_d = (val[7:4] == ATT_ABORT) ? CODE_GOOD : CODE_IMMED;
						stat_d  = stat_d | ST_INTPND | ST_MBFREE;
						if (isel_q != '0) begin
							irq_d = 1'b1;
						end
					end
				end else if (off == OFF_CTRL) begin
					if (val[CT_RESET]) begin
						mbo_d   = '0;
						mbi_d   = '0;
						intst_d = '0;
						stat_d  = ST_MBFREE;
						ready_d = 1'b0;
						attn_d  = '0;
						paddr_d = '0;
						if (isel_q != '0) begin
							irq_d = 1'b0;
						end
					end
					if (val[CT_ICLR]) begin
						stat_d  = stat_d & ~ST_INTPND;
						intst_d = '0;
						if (isel_q != '0) begin
							irq_d = 1'b0;
						end
					end
					if (val[CT_READY]) begin
						ready_d = 1'b1;
					end
				end else if (off[OFF_W-1:2] == '0 || off == OFF_STAT || off == OFF_INTST
						|| off == OFF_READY) begin
					// read-only
				end else begin
					wr.en   = 1'b1;
					wr.addr = off;
					wr.data = val;
					if (off == OFF_INTDEF) begin
						isel_d = irq_lookup(val[2:0]);
					end
				end
			end
			OP_DONE: begin
				stat_d = (stat_q & ~ST_BUSY) | ST_MBFREE;
				if (stat_q[0]) begin
					mbi_d   = paddr_q;
					intst_d = item.completion_ok ? CODE_GOOD : CODE_ERROR;
					stat_d  = stat_d | ST_INTPND;
					if (isel_q != '0) begin
						irq_d = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase

		result.irq_asserted = irq_d;
		result.irq_number   = isel_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbo_q   <= '0;
			mbi_q   <= '0;
			stat_q  <= ST_MBFREE;
			intst_q <= '0;
			ready_q <= 1'b0;
			attn_q  <= '0;
			paddr_q <= '0;
			ptgt_q  <= '0;
			irq_q   <= 1'b0;
			isel_q  <= '0;
		end else if (commit) begin
			mbo_q   <= mbo_d;
			mbi_q   <= mbi_d;
			stat_q  <= stat_d;
			intst_q <= intst_d;
			ready_q <= ready_d;
			attn_q  <= attn_d;
			paddr_q <= paddr_d;
			ptgt_q  <= ptgt_d;
			irq_q   <= irq_d;
			isel_q  <= isel_d;
		end
	end

endmodule

// ----- sv/scsi_host_adapter_mailbox_registers_top.sv -----
// Top level: word pipeline, byte store, output register and configuration port
//
// Host-side register block of a bus-mastering SCSI adapter.
// in_word carries one byte read, byte write or command completion; each word
// accepted on in_valid/in_stall gives exactly one out_word on out_valid/out_stall.
// out_valid rises once the word has passed the read stage: the accepting edge issues the byte-store
// read (a synchronous RAM), and the commit edge updates the registers into the output register.
// Throughput is one word per cycle while out_stall is low; a write to the byte store forwards to a read
// of the same byte that follows it directly.
// When out_stall is high the result holds in the output register; one more word
// can sit in the read stage, after which in_stall rises until the result is taken.
// The slot identifier is written through the APB port where paddr[2] is low and read back
// there; it should only be changed while no word is in flight.
// Reset (arst_n low) clears the mailbox registers, the pipeline and the per-byte valid
// flags, so every byte of the store reads as zero until written; the store needs
// no clearing pass and words are taken from the first cycle after reset.
module scsi_host_adapter_mailbox_registers_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  scsimb_pkg::in_t   in_word,
	output logic              out_valid,
	input  logic              out_stall,
	output scsimb_pkg::out_t  out_word,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import scsimb_pkg::*;

	logic [31:0]           slot_q;
	logic [REG_WINDOW-1:0] valid_q;

	logic             valid_s1;
	in_t              item_s1;
	logic             fwd_s1;
	logic [7:0]       fdata_s1;
	logic             vld_s1;

	logic             out_valid_q;
	out_t             out_word_q;

	logic             adv;
	logic             commit;
	logic             acc;
	logic [OFF_W-1:0] raddr;
	logic [7:0]       ram_rdata;
	logic [7:0]       ram_byte;
	out_t             result;
	wr_t              wr;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == CFG_SLOT_ID) ? slot_q : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == CFG_SLOT_ID) begin
			slot_q <= pwdata;
		end
	end

	assign adv      = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;
	assign acc      = in_valid && !in_stall;
	assign raddr    = win_hit(in_word.port_address) ? win_off(in_word.port_address) : '0;

	scsimb_ram #(
		.WIDTH(8),
		.DEPTH(REG_WINDOW)
	) u_bytes (
		.clk  (clk),
		.we   (commit && wr.en),
		.waddr(wr.addr),
		.wdata(wr.data),
		.re   (acc),
		.raddr(raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (commit && wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1  <= in_word;
			fwd_s1   <= commit && wr.en && (wr.addr == raddr);
			fdata_s1 <= wr.data;
			vld_s1   <= valid_q[raddr];
		end
	end

	assign ram_byte = fwd_s1 ? fdata_s1 : (vld_s1 ? ram_rdata : 8'h00);

	scsimb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.commit  (commit),
		.item    (item_s1),
		.ram_byte(ram_byte),
		.slot_id (slot_q),
		.result  (result),
		.wr      (wr)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule
